// File: src/vwi_pkg.sv
package vwi_pkg;

  // Table geometry: the depth is a power of two so the slot is a bit slice of the hash
  localparam int ADDR_W      = 12;
  localparam int TABLE_DEPTH = 1 << ADDR_W;

  // Dense index width and the capacity that follows from it
  localparam int IDX_W       = 12;
  localparam int INDEX_LIMIT = 1 << IDX_W;
  localparam int CAPACITY    = (TABLE_DEPTH < INDEX_LIMIT) ? TABLE_DEPTH : INDEX_LIMIT;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Position key: three 32-bit float patterns
  localparam int COORD_W = 32;
  localparam int KEY_W   = 3 * COORD_W;

  // Stream widths
  localparam int S_TDATA_W = KEY_W;
  localparam int M_TDATA_W = ((IDX_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 2;

  // Multiplicative mixing constant of the slot hash
  localparam logic [COORD_W-1:0] MIX_MULT = 32'h9E3779B1;
  localparam int FOLD_SHIFT = 15;

  // One table entry
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_MESH_WIPE,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_FIRST,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    HS_X,
    HS_Y,
    HS_Z
  } hash_sel_t;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_NEW,
    RES_FULL
  } res_kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      load_in;
    logic      wipe_start;
    logic      wipe_en;
    logic      hash_en;
    hash_sel_t hash_sel;
    logic      rd_en;
    logic      rd_first;
    logic      probe_step;
    logic      insert;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic wipe_last;
    logic hit;
    logic empty;
    logic probe_last;
    logic room;
    logic out_free;
  } sts_t;

endpackage

// File: src/vwi_ctrl.sv
module vwi_ctrl
  import vwi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tuser,
  output logic s_axis_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.hash_sel  = HS_X;
    cmd.res_kind  = RES_HIT;
    s_axis_tready = 1'b0;
    unique case (state)
      // Sweep the table once after reset
      ST_WIPE: begin
        cmd.wipe_en = 1'b1;
        if (sts.wipe_last) state_next = ST_IDLE;
      end
      // Take a vertex; a mesh start wipes the table first
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          if (s_axis_tuser) begin
            cmd.wipe_start = 1'b1;
            state_next     = ST_MESH_WIPE;
          end else begin
            state_next = ST_H1;
          end
        end
      end
      ST_MESH_WIPE: begin
        cmd.wipe_en = 1'b1;
        if (sts.wipe_last) state_next = ST_H1;
      end
      // Three rounds of the shared multiplier
      ST_H1: begin
        cmd.hash_en  = 1'b1;
        cmd.hash_sel = HS_X;
        state_next   = ST_H2;
      end
      ST_H2: begin
        cmd.hash_en  = 1'b1;
        cmd.hash_sel = HS_Y;
        state_next   = ST_H3;
      end
      ST_H3: begin
        cmd.hash_en  = 1'b1;
        cmd.hash_sel = HS_Z;
        state_next   = ST_FIRST;
      end
      // Read the home slot
      ST_FIRST: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = 1'b1;
        state_next   = ST_CMP;
      end
      // Read the next slot of the probe sequence
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_CMP;
      end
      // Resolve the slot: hit, insert, full, or keep probing
      ST_CMP: begin
        priority if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_HIT;
          state_next   = ST_DONE;
        end else if (sts.empty) begin
          cmd.res_load = 1'b1;
          if (sts.room) begin
            cmd.insert   = 1'b1;
            cmd.res_kind = RES_NEW;
          end else begin
            cmd.res_kind = RES_FULL;
          end
          state_next = ST_DONE;
        end else if (sts.probe_last) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_FULL;
          state_next   = ST_DONE;
        end else begin
          cmd.probe_step = 1'b1;
          state_next     = ST_READ;
        end
      end
      // Hand the result to the output register once it has room
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/vwi_dp.sv
module vwi_dp
  import vwi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output sts_t                 sts,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  entry_t             tbl [TABLE_DEPTH];
  entry_t             rd_q;
  logic [KEY_W-1:0]   key;
  logic [COORD_W-1:0] hash;
  logic [COORD_W-1:0] mul_op;
  logic [COORD_W-1:0] hash_fold;
  logic [ADDR_W-1:0]  first_slot;
  logic [ADDR_W-1:0]  slot;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  probes;
  logic [ADDR_W-1:0]  wipe_addr;
  logic [CNT_W-1:0]   count;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic [IDX_W-1:0]   res_index;
  logic               res_new;
  logic               res_full;
  logic [IDX_W-1:0]   out_index;
  logic               out_new;
  logic               out_full;
  logic               out_valid;

  // Hold the vertex key
  always_ff @(posedge clk) begin
    if (cmd.load_in) key <= s_axis_tdata;
  end

  // Shared multiplier: one mixing round per cycle
  always_comb begin
    unique case (cmd.hash_sel)
      HS_X:    mul_op = key[COORD_W-1:0];
      HS_Y:    mul_op = hash ^ key[2*COORD_W-1:COORD_W];
      HS_Z:    mul_op = hash ^ key[3*COORD_W-1:2*COORD_W];
      default: mul_op = key[COORD_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_en) hash <= COORD_W'(mul_op * MIX_MULT);
  end

  // Fold the high bits down and slice the home slot
  assign hash_fold  = hash ^ (hash >> FOLD_SHIFT);
  assign first_slot = hash_fold[ADDR_W-1:0];
  assign rd_addr    = cmd.rd_first ? first_slot : slot;

  // Advance the probe position; the slot wraps with the address width
  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      slot   <= first_slot;
      probes <= '0;
    end else if (cmd.probe_step) begin
      slot   <= slot + 1'b1;
      probes <= probes + 1'b1;
    end
  end

  // Wipe sweep address and distinct-vertex count
  always_ff @(posedge clk) begin
    if (rst || cmd.wipe_start) begin
      wipe_addr <= '0;
      count     <= '0;
    end else begin
      if (cmd.wipe_en) wipe_addr <= wipe_addr + 1'b1;
      if (cmd.insert)  count     <= count + 1'b1;
    end
  end

  // Single write port: wipe clears valid, insert stores a new entry
  always_comb begin
    wr_en         = cmd.wipe_en || cmd.insert;
    wr_addr       = cmd.wipe_en ? wipe_addr : slot;
    wr_data.valid = cmd.insert;
    wr_data.id    = IDX_W'(count);
    wr_data.key   = key;
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) tbl[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q <= tbl[rd_addr];
  end

  // Status of the slot just read
  always_comb begin
    sts.wipe_last  = (wipe_addr == {ADDR_W{1'b1}});
    sts.hit        = rd_q.valid && (rd_q.key == key);
    sts.empty      = !rd_q.valid;
    sts.probe_last = (probes == {ADDR_W{1'b1}});
    sts.room       = (count < CNT_W'(CAPACITY));
    sts.out_free   = !out_valid || m_axis_tready;
  end

  // Capture the result of this vertex
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        RES_HIT: begin
          res_index <= rd_q.id;
          res_new   <= 1'b0;
          res_full  <= 1'b0;
        end
        RES_NEW: begin
          res_index <= IDX_W'(count);
          res_new   <= 1'b1;
          res_full  <= 1'b0;
        end
        default: begin
          res_index <= '0;
          res_new   <= 1'b0;
          res_full  <= 1'b1;
        end
      endcase
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index <= res_index;
      out_new   <= res_new;
      out_full  <= res_full;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_TDATA_W'(out_index);
  assign m_axis_tuser  = {out_full, out_new};

endmodule

// File: src/vertex_weld_indexer_core.sv
// Channel   Direction  Payload
// s_axis    in         tdata: pos_x, pos_y, pos_z; tuser: mesh_start
// m_axis    out        tdata: vertex_index; tuser: is_new, table_full
//
// One vertex at a time. From accept, an item passes through the hash states, a read of its
// home slot and a compare before its result is registered; each further slot of the linear
// probe adds one synchronous table read and one compare. The hash mixes x, y and z in turn on
// one shared 32x32 multiplier. A mesh start adds a wipe of the valid bits of all 4096 table
// entries, one entry a cycle; the same wipe runs after reset before the first vertex is taken.
// A result waits in the output register while the next vertex is accepted and hashed.
module vertex_weld_indexer_core
  import vwi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
  input  logic                 s_axis_tuser,  // [0] mesh_start
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [11:0] vertex_index, [15:12] zero
  output logic [M_TUSER_W-1:0] m_axis_tuser   // [0] is_new, [1] table_full
);

  cmd_t cmd;
  sts_t sts;

  vwi_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  vwi_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .s_axis_tdata  (s_axis_tdata),
    .sts           (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
